### hdl/gmps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid maximum path sum: shared package
// Widths, register indexes and the broadcast bundle that the top level
// drives into every cell of the line-sum chain.
// ----------------------------------------------------------------------------
package gmps_pkg;

   localparam int COIN_W       = 16;
   localparam int SUM_W        = 24;
   localparam int CFG_W        = 8;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_ADDR_W   = 3;
   localparam int DEF_MAX_COLS = 128;
   localparam int DEF_MAX_ROWS = 128;

   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

   localparam logic CSR_GRID_ROWS = 1'b0;
   localparam logic CSR_GRID_COLS = 1'b1;

   typedef struct packed {
      logic             shift;
      logic [SUM_W-1:0] sum;
   } cell_bcast_type;

endpackage

### hdl/gmps_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid maximum path sum: line-sum cell
// Holds one accumulated sum of the previous row. On every accepted
// transaction it takes its neighbor's value, or the new sum when it is
// the cell where the line currently begins.
// ----------------------------------------------------------------------------
module gmps_cell #(
   parameter int COL_W      = 7,
   parameter int CELL_INDEX = 0
) (
   input  logic                          clock,
   input  gmps_pkg::cell_bcast_type      bcast,
   input  logic [COL_W-1:0]              inject_pos,
   input  logic [gmps_pkg::SUM_W-1:0]    prev_sum,
   output logic [gmps_pkg::SUM_W-1:0]    cell_sum
);

   logic [gmps_pkg::SUM_W-1:0] sum_ff;
   logic [gmps_pkg::SUM_W-1:0] sum_in;

   assign sum_in   = (inject_pos == COL_W'(CELL_INDEX)) ? bcast.sum : prev_sum;
   assign cell_sum = sum_ff;

   always_ff @(posedge clock) begin
      if (bcast.shift) begin
         sum_ff <= sum_in;
      end
   end

endmodule

### hdl/grid_max_path_sum.sv
`timescale 1ns / 1ps
// Latency: a result appears in the cycle after its transaction is accepted.
// Throughput: one cell per cycle unless stalled; the previous row's sums
// travel through a cell chain that shifts once per accepted transaction.
// Reset clears the sizes to one row and one column, the position and the
// left sum; the line-sum chain is not cleared and is written before use.
// ----------------------------------------------------------------------------
// Grid maximum path sum: top level
// Forms the best right/down accumulated coin sum for each cell of a grid
// streamed in row-major order and marks the final cell of the grid.
// ----------------------------------------------------------------------------
module grid_max_path_sum #(
   parameter int MAX_COLS = gmps_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS = gmps_pkg::DEF_MAX_ROWS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [gmps_pkg::COIN_W-1:0]       req_coins,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [gmps_pkg::SUM_W-1:0]        rsp_best_sum,
   output logic                              rsp_grid_done,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [gmps_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [gmps_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [gmps_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int SUM_W = gmps_pkg::SUM_W;

   logic [gmps_pkg::CFG_W-1:0] grid_rows_ff, grid_rows_in;
   logic [gmps_pkg::CFG_W-1:0] grid_cols_ff, grid_cols_in;
   logic [ROW_W-1:0]           rows_last_ff, rows_last_in;
   logic [COL_W-1:0]           cols_last_ff, cols_last_in;
   logic [COL_W-1:0]           inject_pos_ff, inject_pos_in;
   logic [ROW_W-1:0]           row_pos_ff, row_pos_in;
   logic [COL_W-1:0]           col_pos_ff, col_pos_in;
   logic [SUM_W-1:0]           left_sum_ff, left_sum_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0]           rsp_sum_ff;
   logic                       rsp_done_ff;

   logic                       csr_write;
   logic [31:0]                wr_value;
   logic                       req_accept;
   logic                       row_first;
   logic                       col_first;
   logic                       col_last;
   logic                       row_last;
   logic [SUM_W-1:0]           above_sum;
   logic [SUM_W-1:0]           best_prior;
   logic [SUM_W:0]             sum_wide;
   logic [SUM_W-1:0]           cell_sum_new;
   gmps_pkg::cell_bcast_type   bcast;
   logic [SUM_W-1:0]           chain [MAX_COLS];

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign wr_value   = {24'd0, csr_pwdata[gmps_pkg::CFG_W-1:0]};

   always_comb begin
      grid_rows_in  = grid_rows_ff;
      grid_cols_in  = grid_cols_ff;
      rows_last_in  = rows_last_ff;
      cols_last_in  = cols_last_ff;
      inject_pos_in = inject_pos_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            gmps_pkg::CSR_GRID_ROWS: begin
               grid_rows_in = csr_pwdata[gmps_pkg::CFG_W-1:0];
               if (wr_value == 32'd0) begin
                  rows_last_in = '0;
               end else if (wr_value > 32'(MAX_ROWS)) begin
                  rows_last_in = ROW_W'(MAX_ROWS - 1);
               end else begin
                  rows_last_in = ROW_W'(wr_value - 32'd1);
               end
            end
            gmps_pkg::CSR_GRID_COLS: begin
               grid_cols_in = csr_pwdata[gmps_pkg::CFG_W-1:0];
               if (wr_value == 32'd0) begin
                  cols_last_in = '0;
               end else if (wr_value > 32'(MAX_COLS)) begin
                  cols_last_in = COL_W'(MAX_COLS - 1);
               end else begin
                  cols_last_in = COL_W'(wr_value - 32'd1);
               end
               inject_pos_in = COL_W'(MAX_COLS - 1) - cols_last_in;
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         gmps_pkg::CSR_GRID_ROWS: csr_prdata = {24'd0, grid_rows_ff};
         gmps_pkg::CSR_GRID_COLS: csr_prdata = {24'd0, grid_cols_ff};
      endcase
   end

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   assign row_first = (row_pos_ff == '0);
   assign col_first = (col_pos_ff == '0);
   assign col_last  = (col_pos_ff == cols_last_ff);
   assign row_last  = (row_pos_ff == rows_last_ff);
   assign above_sum = chain[MAX_COLS-1];

   always_comb begin
      if (!row_first && !col_first) begin
         best_prior = (above_sum > left_sum_ff) ? above_sum : left_sum_ff;
      end else if (!row_first) begin
         best_prior = above_sum;
      end else if (!col_first) begin
         best_prior = left_sum_ff;
      end else begin
         best_prior = '0;
      end
      sum_wide     = {1'b0, best_prior} + (SUM_W + 1)'(req_coins);
      cell_sum_new = sum_wide[SUM_W] ? gmps_pkg::SUM_MAX : sum_wide[SUM_W-1:0];
   end

   always_comb begin
      row_pos_in  = row_pos_ff;
      col_pos_in  = col_pos_ff;
      left_sum_in = left_sum_ff;
      if (csr_write) begin
         row_pos_in  = '0;
         col_pos_in  = '0;
         left_sum_in = '0;
      end else if (req_accept) begin
         if (col_last) begin
            col_pos_in  = '0;
            left_sum_in = '0;
            row_pos_in  = row_last ? '0 : row_pos_ff + ROW_W'(1);
         end else begin
            col_pos_in  = col_pos_ff + COL_W'(1);
            left_sum_in = cell_sum_new;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_rows_ff  <= gmps_pkg::CFG_W'(1);
         grid_cols_ff  <= gmps_pkg::CFG_W'(1);
         rows_last_ff  <= '0;
         cols_last_ff  <= '0;
         inject_pos_ff <= COL_W'(MAX_COLS - 1);
         row_pos_ff    <= '0;
         col_pos_ff    <= '0;
         left_sum_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         grid_rows_ff  <= grid_rows_in;
         grid_cols_ff  <= grid_cols_in;
         rows_last_ff  <= rows_last_in;
         cols_last_ff  <= cols_last_in;
         inject_pos_ff <= inject_pos_in;
         row_pos_ff    <= row_pos_in;
         col_pos_ff    <= col_pos_in;
         left_sum_ff   <= left_sum_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_sum_ff  <= cell_sum_new;
         rsp_done_ff <= row_last && col_last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_best_sum  = rsp_sum_ff;
   assign rsp_grid_done = rsp_done_ff;

   assign bcast.shift = req_accept;
   assign bcast.sum   = cell_sum_new;

   for (genvar i = 0; i < MAX_COLS; i++) begin : g_cell
      logic [SUM_W-1:0] prev_sum;
      if (i == 0) begin : g_head
         assign prev_sum = '0;
      end else begin : g_body
         assign prev_sum = chain[i-1];
      end
      gmps_cell #(
         .COL_W      (COL_W),
         .CELL_INDEX (i)
      ) u_cell (
         .clock      (clock),
         .bcast      (bcast),
         .inject_pos (inject_pos_ff),
         .prev_sum   (prev_sum),
         .cell_sum   (chain[i])
      );
   end

   a_col_in_range: assert property (@(posedge clock) disable iff (reset)
      col_pos_ff <= cols_last_ff)
      else $error("column position beyond grid width");

   a_row_in_range: assert property (@(posedge clock) disable iff (reset)
      row_pos_ff <= rows_last_ff)
      else $error("row position beyond grid height");

   a_wrap_after_done: assert property (@(posedge clock) disable iff (reset)
      (req_accept && row_last && col_last && !csr_write) |=>
         (row_pos_ff == '0 && col_pos_ff == '0 && left_sum_ff == '0))
      else $error("position did not wrap after final cell");

   a_sum_covers_coins: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (rsp_sum_ff >= SUM_W'($past(req_coins))))
      else $error("accumulated sum below the cell's own coins");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid_ff && !rsp_ready))
      else $error("input stalled while output register can drain");

endmodule
